### src/text_console_glyph_engine_unit_defines.svh
// Assertion macros for the glyph engine
`ifndef TEXT_CONSOLE_GLYPH_ENGINE_UNIT_DEFINES_SVH
`define TEXT_CONSOLE_GLYPH_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define TCGE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);
`define TCGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TCGE_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define TCGE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

### src/tcge_pkg.sv
package tcge_pkg;

    localparam int CFG_IDX_W = 1;
    localparam int ALU_W     = 12;

    localparam logic [1:0] OP_WRITE_CHAR = 2'd0;
    localparam logic [1:0] OP_SET_CURSOR = 2'd1;
    localparam logic [1:0] OP_CLEAR      = 2'd2;
    localparam logic [1:0] OP_LOAD_FONT  = 2'd3;

    localparam logic [1:0] CMD_DRAW   = 2'd0;
    localparam logic [1:0] CMD_SCROLL = 2'd1;
    localparam logic [1:0] CMD_CLEAR  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_COLS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_ROWS = 1'b1;

    localparam logic [7:0] COLS_RESET = 8'd80;
    localparam logic [7:0] ROWS_RESET = 8'd30;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_TAB = 8'h09;

    localparam logic [ALU_W-1:0] TAB_STEP = 12'd8;

    typedef struct packed {
        logic [ALU_W-1:0] a;
        logic [ALU_W-1:0] b;
        logic [ALU_W-1:0] lim;
        logic             align;
    } t_alu_req;

    typedef struct packed {
        logic [ALU_W-1:0] res;
        logic             ge;
    } t_alu_rsp;

endpackage

### src/tcge_if.sv
interface tcge_in_if import tcge_pkg::*; ();
    logic       valid;
    logic       ready;
    logic [1:0] operation;
    logic [7:0] char_code;
    logic [7:0] target_row;
    logic [7:0] target_col;
    logic [3:0] glyph_line;
    logic [7:0] glyph_bits;

    modport source (output valid, operation, char_code, target_row, target_col,
                    glyph_line, glyph_bits, input ready);
    modport sink   (input valid, operation, char_code, target_row, target_col,
                    glyph_line, glyph_bits, output ready);
endinterface

interface tcge_out_if import tcge_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [1:0]  command;
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  line_mask;
    logic [7:0]  cursor_row_now;
    logic [7:0]  cursor_col_now;
    logic        last;

    modport source (output valid, command, pixel_x, pixel_y, line_mask,
                    cursor_row_now, cursor_col_now, last, input ready);
    modport sink   (input valid, command, pixel_x, pixel_y, line_mask,
                    cursor_row_now, cursor_col_now, last, output ready);
endinterface

interface tcge_cfg_if import tcge_pkg::*; ();
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] reg_index;
    logic [7:0]           reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

### src/text_console_glyph_engine_unit.sv
// Printable character: 16 draw transactions at one per cycle unless the output
// stalls, via S_CHAR, S_ROW and S_DRAW, then a scroll transaction if needed; the
// input is busy until the last is loaded. Newline, return, tab: S_CHAR, S_ROW and
// maybe a scroll; set cursor S_SETR, S_SETC; clear S_CLEAR; font load on accept.
// One item at a time, shared adder. Synchronous active-low reset: cursor at home,
// limits 80 x 30, no pending transaction; font store contents are not cleared.
`include "text_console_glyph_engine_unit_defines.svh"

module text_console_glyph_engine_unit import tcge_pkg::*; #(
    parameter int GLYPH_LINES = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tcge_in_if.sink       i_in,
    tcge_out_if.source    o_out,
    tcge_cfg_if.sink      i_cfg
);

    localparam int LW = $clog2(GLYPH_LINES);
    localparam int CW = $clog2(GLYPH_LINES + 1);
    localparam int GW = (CW > 4) ? CW : 4;
    localparam int AW = 8 + LW;
    localparam logic [LW-1:0] LAST_LN = LW'(GLYPH_LINES - 1);

    typedef enum logic [2:0] {
        S_IDLE, S_SETR, S_SETC, S_CHAR, S_ROW, S_DRAW, S_SCROLL, S_CLEAR
    } t_state;

    t_state      r_state, n_state;
    logic [7:0]  r_cols, r_rows;
    logic [7:0]  r_cur_row, n_cur_row;
    logic [7:0]  r_cur_col, n_cur_col;
    logic [7:0]  r_code, r_trow, r_tcol;
    logic [7:0]  r_draw_col, n_draw_col;
    logic [11:0] r_base_y, n_base_y;
    logic        r_row_inc, n_row_inc;
    logic        r_print, n_print;
    logic        r_scroll, n_scroll;
    logic [LW-1:0] r_ln, n_ln;

    logic        r_ovalid, n_ovalid;
    logic [1:0]  r_cmd, n_cmd;
    logic [10:0] r_px, n_px;
    logic [11:0] r_py, n_py;
    logic [7:0]  r_mask, n_mask;
    logic [7:0]  r_orow, n_orow;
    logic [7:0]  r_ocol, n_ocol;
    logic        r_last, n_last;

    logic [7:0]  cols_eff, rows_eff;
    logic        in_acc, slot_free, load_out;
    logic [GW-1:0] gline_ext;
    logic        gline_ok;
    logic          mem_we, mem_re;
    logic [AW-1:0] mem_waddr, mem_raddr;
    logic [7:0]    mem_rdata;
    t_alu_req    alu_req;
    t_alu_rsp    alu_rsp;

    assign cols_eff  = (r_cols == 8'd0) ? 8'd1 : r_cols;
    assign rows_eff  = (r_rows == 8'd0) ? 8'd1 : r_rows;
    assign in_acc    = i_in.valid && i_in.ready;
    assign slot_free = !r_ovalid || o_out.ready;
    assign gline_ext = GW'(i_in.glyph_line);
    assign gline_ok  = gline_ext < GW'(GLYPH_LINES);

    assign mem_we    = in_acc && (i_in.operation == OP_LOAD_FONT) && gline_ok;
    assign mem_waddr = {i_in.char_code, gline_ext[LW-1:0]};

    tcge_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    tcge_font_mem #(.AW(AW)) u_font (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (i_in.glyph_bits),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    // shared adder operand select
    always_comb begin
        alu_req = '0;
        unique case (r_state)
            S_SETR: begin
                alu_req.a   = ALU_W'(r_trow);
                alu_req.lim = ALU_W'(rows_eff);
            end
            S_SETC: begin
                alu_req.a   = ALU_W'(r_tcol);
                alu_req.lim = ALU_W'(cols_eff);
            end
            S_CHAR: begin
                alu_req.a     = ALU_W'(r_cur_col);
                alu_req.b     = (r_code == CH_TAB) ? TAB_STEP : ALU_W'(1);
                alu_req.lim   = ALU_W'(cols_eff);
                alu_req.align = (r_code == CH_TAB);
            end
            S_ROW: begin
                alu_req.a   = ALU_W'(r_cur_row);
                alu_req.b   = ALU_W'(r_row_inc);
                alu_req.lim = ALU_W'(rows_eff);
            end
            S_DRAW: begin
                alu_req.a = r_base_y;
                alu_req.b = ALU_W'(r_ln);
            end
            default: begin
                alu_req = '0;
            end
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_cur_row  = r_cur_row;
        n_cur_col  = r_cur_col;
        n_draw_col = r_draw_col;
        n_base_y   = r_base_y;
        n_row_inc  = r_row_inc;
        n_print    = r_print;
        n_scroll   = r_scroll;
        n_ln       = r_ln;
        mem_re     = 1'b0;
        mem_raddr  = {r_code, r_ln};
        load_out   = 1'b0;
        n_cmd      = r_cmd;
        n_px       = r_px;
        n_py       = r_py;
        n_mask     = r_mask;
        n_orow     = r_orow;
        n_ocol     = r_ocol;
        n_last     = r_last;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    unique case (i_in.operation)
                        OP_WRITE_CHAR: n_state = S_CHAR;
                        OP_SET_CURSOR: n_state = S_SETR;
                        OP_CLEAR: begin
                            n_cur_row = 8'd0;
                            n_cur_col = 8'd0;
                            n_state   = S_CLEAR;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_SETR: begin
                if (!alu_rsp.ge) begin
                    n_cur_row = r_trow;
                end
                n_state = S_SETC;
            end
            S_SETC: begin
                if (!alu_rsp.ge) begin
                    n_cur_col = r_tcol;
                end
                n_state = S_IDLE;
            end
            S_CHAR: begin
                n_print    = 1'b0;
                n_scroll   = 1'b0;
                n_draw_col = r_cur_col;
                n_base_y   = 12'(r_cur_row * GLYPH_LINES);
                n_ln       = '0;
                case (r_code)
                    CH_NL: begin
                        n_cur_col = 8'd0;
                        n_row_inc = 1'b1;
                    end
                    CH_CR: begin
                        n_cur_col = 8'd0;
                        n_row_inc = 1'b0;
                    end
                    default: begin
                        n_print   = (r_code != CH_TAB);
                        n_cur_col = alu_rsp.ge ? 8'd0 : alu_rsp.res[7:0];
                        n_row_inc = alu_rsp.ge;
                        mem_re    = (r_code != CH_TAB);
                        mem_raddr = {r_code, LW'(0)};
                    end
                endcase
                n_state = S_ROW;
            end
            S_ROW: begin
                n_scroll  = alu_rsp.ge;
                n_cur_row = alu_rsp.ge ? (rows_eff - 8'd1) : alu_rsp.res[7:0];
                if (r_print) begin
                    n_state = S_DRAW;
                end else if (alu_rsp.ge) begin
                    n_state = S_SCROLL;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_DRAW: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_cmd    = CMD_DRAW;
                    n_px     = {r_draw_col, 3'b000};
                    n_py     = alu_rsp.res;
                    n_mask   = mem_rdata;
                    n_orow   = r_cur_row;
                    n_ocol   = r_cur_col;
                    n_last   = (r_ln == LAST_LN) && !r_scroll;
                    if (r_ln == LAST_LN) begin
                        n_state = r_scroll ? S_SCROLL : S_IDLE;
                    end else begin
                        n_ln      = r_ln + LW'(1);
                        mem_re    = 1'b1;
                        mem_raddr = {r_code, r_ln + LW'(1)};
                    end
                end
            end
            S_SCROLL, S_CLEAR: begin
                if (slot_free) begin
                    load_out = 1'b1;
                    n_cmd    = (r_state == S_SCROLL) ? CMD_SCROLL : CMD_CLEAR;
                    n_px     = '0;
                    n_py     = '0;
                    n_mask   = '0;
                    n_orow   = r_cur_row;
                    n_ocol   = r_cur_col;
                    n_last   = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase

        if (load_out) begin
            n_ovalid = 1'b1;
        end else if (o_out.ready) begin
            n_ovalid = 1'b0;
        end else begin
            n_ovalid = r_ovalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_cols    <= COLS_RESET;
            r_rows    <= ROWS_RESET;
            r_cur_row <= 8'd0;
            r_cur_col <= 8'd0;
            r_ovalid  <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_cur_row <= n_cur_row;
            r_cur_col <= n_cur_col;
            r_ovalid  <= n_ovalid;
            if (i_cfg.valid && i_cfg.ready) begin
                unique case (i_cfg.reg_index)
                    REG_SCREEN_COLS: r_cols <= i_cfg.reg_data;
                    REG_SCREEN_ROWS: r_rows <= i_cfg.reg_data;
                    default: r_cols <= r_cols;
                endcase
            end
        end
        if (in_acc) begin
            r_code <= i_in.char_code;
            r_trow <= i_in.target_row;
            r_tcol <= i_in.target_col;
        end
        r_draw_col <= n_draw_col;
        r_base_y   <= n_base_y;
        r_row_inc  <= n_row_inc;
        r_print    <= n_print;
        r_scroll   <= n_scroll;
        r_ln       <= n_ln;
        r_cmd      <= n_cmd;
        r_px       <= n_px;
        r_py       <= n_py;
        r_mask     <= n_mask;
        r_orow     <= n_orow;
        r_ocol     <= n_ocol;
        r_last     <= n_last;
    end

    assign i_in.ready           = (r_state == S_IDLE);
    assign i_cfg.ready          = 1'b1;
    assign o_out.valid          = r_ovalid;
    assign o_out.command        = r_cmd;
    assign o_out.pixel_x        = r_px;
    assign o_out.pixel_y        = r_py;
    assign o_out.line_mask      = r_mask;
    assign o_out.cursor_row_now = r_orow;
    assign o_out.cursor_col_now = r_ocol;
    assign o_out.last           = r_last;

    `TCGE_ASSERT_NEXT(a_busy_after_accept, i_clk, i_rst_n, in_acc && (i_in.operation != OP_LOAD_FONT), !i_in.ready, "input still ready after a working transaction")
    `TCGE_ASSERT_SAME(a_scroll_is_last, i_clk, i_rst_n, o_out.valid && (o_out.command == CMD_SCROLL), o_out.last, "scroll transaction not marked last")
    `TCGE_ASSERT_SAME(a_clear_home, i_clk, i_rst_n, o_out.valid && (o_out.command == CMD_CLEAR), o_out.last && (o_out.cursor_row_now == 8'd0) && (o_out.cursor_col_now == 8'd0), "clear transaction not at home")
    `TCGE_ASSERT_SAME(a_draw_in_print, i_clk, i_rst_n, r_state == S_DRAW, r_print, "draw state entered without a printable character")

endmodule

### src/tcge_alu.sv
module tcge_alu import tcge_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [ALU_W-1:0] sum;
    logic [ALU_W-1:0] res;

    assign sum = i_req.a + i_req.b;
    // align rounds down to a tab stop
    assign res = i_req.align ? {sum[ALU_W-1:3], 3'b000} : sum;

    assign o_rsp.res = res;
    assign o_rsp.ge  = (res >= i_req.lim);

endmodule

### src/tcge_font_mem.sv
module tcge_font_mem #(
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  logic [7:0]    i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output logic [7:0]    o_rdata
);

    logic [7:0] r_mem [(1 << AW)];
    logic [7:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule
